// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PDE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pde assertion failed");

// next-cycle implication
`define PDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pde assertion failed");

`endif

// ===== rtl/pde_pkg.sv =====
package pde_pkg;

	localparam int COORD_W        = 32;
	localparam int DIST_W         = 40;
	localparam int OUT_IDX_W      = 16;
	localparam int PROD_W         = 64;
	localparam int MAX_POINTS_DEF = 65536;
	localparam int FRONT_STAGES   = 4;
	localparam int MID_DEPTH      = 8;
	localparam int RES_DEPTH      = 2;
	localparam int CFG_IDX_W      = 8;
	localparam int FRAC_SHIFT     = 30;

	localparam logic signed [COORD_W-1:0] NORMAL_Z_RESET = 32'sh4000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NORMAL_X     = 8'd0,
		CFG_NORMAL_Y     = 8'd1,
		CFG_NORMAL_Z     = 8'd2,
		CFG_PLANE_OFFSET = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] normal_x;
		logic signed [COORD_W-1:0] normal_y;
		logic signed [COORD_W-1:0] normal_z;
		logic signed [COORD_W-1:0] offset;
	} plane_t;

	typedef struct packed {
		logic signed [DIST_W-1:0] distance;
		logic                     last;
	} item_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0]     min_index;
		logic [OUT_IDX_W-1:0]     max_index;
		logic signed [DIST_W-1:0] min_distance;
		logic signed [DIST_W-1:0] max_distance;
		logic                     overflow;
	} result_t;

endpackage

// ===== rtl/pde_fifo.sv =====
module pde_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           push_data,
	input  logic                       pop,
	output logic [WIDTH-1:0]           pop_data,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic                       full,
	output logic                       empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign count    = count_q;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/pde_front.sv =====
module pde_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic signed [pde_pkg::COORD_W-1:0] x_in,
	input  logic signed [pde_pkg::COORD_W-1:0] y_in,
	input  logic signed [pde_pkg::COORD_W-1:0] z_in,
	input  logic                             last_in,
	input  pde_pkg::plane_t                  plane,
	output logic                             out_valid,
	output pde_pkg::item_t                   out_item,
	output logic [$clog2(pde_pkg::FRONT_STAGES+1)-1:0] occupancy
);
	import pde_pkg::*;

	localparam int OCC_W = $clog2(FRONT_STAGES+1);
	localparam int SUM_W = PROD_W + 1;
	localparam int TOT_W = PROD_W + 2;
	localparam int SHR_W = TOT_W - FRAC_SHIFT;
	localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) <<< (FRAC_SHIFT - 1);

	logic                      v_s1, v_s2, v_s3, v_s4;
	logic                      last_s1, last_s2, last_s3, last_s4;
	logic signed [COORD_W-1:0] x_s1, y_s1, z_s1;
	logic signed [PROD_W-1:0]  px_s2, py_s2, pz_s2;
	logic signed [SUM_W-1:0]   sxy_s3, pzr_s3;
	logic signed [DIST_W-1:0]  dist_s4;
	logic signed [PROD_W-1:0]  px, py, pz;
	logic signed [TOT_W-1:0]   total;
	logic signed [DIST_W-1:0]  dist_sum;

	// exact q18.46 products
	assign px = plane.normal_x * x_s1;
	assign py = plane.normal_y * y_s1;
	assign pz = plane.normal_z * z_s1;

	// round half up to q16.16, then add the offset
	assign total    = {sxy_s3[SUM_W-1], sxy_s3} + {pzr_s3[SUM_W-1], pzr_s3};
	assign dist_sum = {{(DIST_W-SHR_W){total[TOT_W-1]}}, total[TOT_W-1:FRAC_SHIFT]}
	                + {{(DIST_W-COORD_W){plane.offset[COORD_W-1]}}, plane.offset};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x_in;
		y_s1    <= y_in;
		z_s1    <= z_in;
		last_s1 <= last_in;
		px_s2   <= px;
		py_s2   <= py;
		pz_s2   <= pz;
		last_s2 <= last_s1;
		sxy_s3  <= {px_s2[PROD_W-1], px_s2} + {py_s2[PROD_W-1], py_s2};
		pzr_s3  <= {pz_s2[PROD_W-1], pz_s2} + ROUND_BIAS;
		last_s3 <= last_s2;
		dist_s4 <= dist_sum;
		last_s4 <= last_s3;
	end

	assign out_valid         = v_s4;
	assign out_item.distance = dist_s4;
	assign out_item.last     = last_s4;
	assign occupancy         = OCC_W'(v_s1) + OCC_W'(v_s2) + OCC_W'(v_s3) + OCC_W'(v_s4);

endmodule

// ===== rtl/pde_back.sv =====
module pde_back #(
	parameter int MAX_POINTS = pde_pkg::MAX_POINTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  pde_pkg::item_t   item,
	output logic             item_pop,
	input  logic             res_full,
	output logic             res_push,
	output pde_pkg::result_t res_data
);
	import pde_pkg::*;

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS+1);

	logic [CNT_W-1:0]         count_q;
	logic                     have_q;
	logic                     ovf_q;
	logic signed [DIST_W-1:0] low_q, high_q;
	logic [IDX_W-1:0]         low_idx_q, high_idx_q;

	logic                     sat;
	logic [IDX_W-1:0]         idx;
	logic                     take_low, take_high;
	logic signed [DIST_W-1:0] low_n, high_n;
	logic [IDX_W-1:0]         low_idx_n, high_idx_n;
	logic                     ovf_n;
	logic [IDX_W+OUT_IDX_W-1:0] low_idx_ext, high_idx_ext;

	assign item_pop = item_valid && !res_full;
	assign sat      = (count_q >= CNT_W'(MAX_POINTS));
	assign idx      = sat ? IDX_W'(MAX_POINTS-1) : count_q[IDX_W-1:0];

	// ties keep the earliest index
	assign take_low  = !have_q || (item.distance < low_q);
	assign take_high = !have_q || (item.distance > high_q);

	assign low_n      = take_low  ? item.distance : low_q;
	assign high_n     = take_high ? item.distance : high_q;
	assign low_idx_n  = take_low  ? idx : low_idx_q;
	assign high_idx_n = take_high ? idx : high_idx_q;
	assign ovf_n      = ovf_q || sat;

	assign low_idx_ext  = {{OUT_IDX_W{1'b0}}, low_idx_n};
	assign high_idx_ext = {{OUT_IDX_W{1'b0}}, high_idx_n};

	assign res_push              = item_pop && item.last;
	assign res_data.min_index    = low_idx_ext[OUT_IDX_W-1:0];
	assign res_data.max_index    = high_idx_ext[OUT_IDX_W-1:0];
	assign res_data.min_distance = low_n;
	assign res_data.max_distance = high_n;
	assign res_data.overflow     = ovf_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			have_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (item_pop) begin
			if (item.last) begin
				count_q <= '0;
				have_q  <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= sat ? count_q : count_q + 1'b1;
				have_q  <= 1'b1;
				ovf_q   <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			low_q      <= low_n;
			high_q     <= high_n;
			low_idx_q  <= low_idx_n;
			high_idx_q <= high_idx_n;
		end
	end

endmodule

// ===== rtl/plane_distance_extremes.sv =====
// Signed point-to-plane distance extremes over a streamed point cloud. Push one point
// (Q16.16 x, y, z) per clock while full is low; the distance n.p + d is formed in a
// four-stage front pipeline (input register, 32x32 products, partial sums, round and
// offset), queued in an eight-entry buffer, and folded into running min/max by the
// back tracker, one point per clock while the result queue has room. The point
// flagged last_point yields one result on the output queue with both indices
// (earliest on ties), both distances (40-bit Q24.16) and an index overflow flag;
// tracking then restarts for the next cloud. Sustained rate is one point per cycle
// while the result queue is drained. full rises once eight points sit in the
// front pipeline and buffer together, which happens only when the result queue
// (two entries) is not drained. Write the plane registers only while no point is in flight.
`include "assert_macros.svh"

module plane_distance_extremes #(
	parameter int MAX_POINTS = pde_pkg::MAX_POINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [pde_pkg::COORD_W-1:0]  x_coord,
	input  logic signed [pde_pkg::COORD_W-1:0]  y_coord,
	input  logic signed [pde_pkg::COORD_W-1:0]  z_coord,
	input  logic                                last_point,
	output logic                                empty,
	input  logic                                pop,
	output logic [pde_pkg::OUT_IDX_W-1:0]       min_index,
	output logic [pde_pkg::OUT_IDX_W-1:0]       max_index,
	output logic signed [pde_pkg::DIST_W-1:0]   min_distance,
	output logic signed [pde_pkg::DIST_W-1:0]   max_distance,
	output logic                                index_overflow,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pde_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pde_pkg::COORD_W-1:0]         cfg_data
);
	import pde_pkg::*;

	localparam int OCC_W = $clog2(FRONT_STAGES+1);
	localparam int MCT_W = $clog2(MID_DEPTH+1);
	localparam int RCT_W = $clog2(RES_DEPTH+1);
	localparam int INF_W = $clog2(MID_DEPTH+FRONT_STAGES+1);

	plane_t           plane_q;
	logic             accept;
	logic             front_valid;
	item_t            front_item;
	logic [OCC_W-1:0] front_occ;
	logic             mid_pop, mid_full, mid_empty;
	item_t            mid_item;
	logic [MCT_W-1:0] mid_count;
	logic             res_push, res_full;
	result_t          res_in, res_out;
	logic [RCT_W-1:0] res_count;
	logic [INF_W-1:0] inflight;

	// config register transaction
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q.normal_x <= '0;
			plane_q.normal_y <= '0;
			plane_q.normal_z <= NORMAL_Z_RESET;
			plane_q.offset   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_NORMAL_X:     plane_q.normal_x <= cfg_data;
				CFG_NORMAL_Y:     plane_q.normal_y <= cfg_data;
				CFG_NORMAL_Z:     plane_q.normal_z <= cfg_data;
				CFG_PLANE_OFFSET: plane_q.offset   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// credit: front stages plus buffer never exceed the buffer depth
	assign inflight = INF_W'(front_occ) + INF_W'(mid_count);
	assign full     = (inflight >= INF_W'(MID_DEPTH));
	assign accept   = push && !full;

	pde_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.x_in      (x_coord),
		.y_in      (y_coord),
		.z_in      (z_coord),
		.last_in   (last_point),
		.plane     (plane_q),
		.out_valid (front_valid),
		.out_item  (front_item),
		.occupancy (front_occ)
	);

	pde_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_data (front_item),
		.pop       (mid_pop),
		.pop_data  (mid_item),
		.count     (mid_count),
		.full      (mid_full),
		.empty     (mid_empty)
	);

	pde_back #(
		.MAX_POINTS (MAX_POINTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!mid_empty),
		.item       (mid_item),
		.item_pop   (mid_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_data   (res_in)
	);

	pde_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_in),
		.pop       (pop),
		.pop_data  (res_out),
		.count     (res_count),
		.full      (res_full),
		.empty     (empty)
	);

	assign min_index      = res_out.min_index;
	assign max_index      = res_out.max_index;
	assign min_distance   = res_out.min_distance;
	assign max_distance   = res_out.max_distance;
	assign index_overflow = res_out.overflow;

	`PDE_ASSERT_IMPL(a_credit_bound, clk, arst_n, 1'b1, inflight <= INF_W'(MID_DEPTH))
	`PDE_ASSERT_IMPL(a_mid_no_overrun, clk, arst_n, front_valid, !mid_full || mid_pop)
	`PDE_ASSERT_IMPL(a_res_no_overrun, clk, arst_n, res_push, !res_full)
	`PDE_ASSERT_IMPL(a_res_ordered, clk, arst_n, res_count != '0,
		res_out.min_distance <= res_out.max_distance)

endmodule

// ===== sim/tb_plane_distance_extremes.sv =====
`timescale 1ns / 100ps

module tb_plane_distance_extremes;
	import pde_pkg::*;

	localparam int MAX_PTS = MAX_POINTS_DEF;
	localparam int CFG_FIRST_UNMAPPED = 4;
	localparam int CFG_LAST_INDEX = 255;
	localparam int RANDOM_ITEMS = 1600;
	localparam int PHASE_ITEMS = 150;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic last;
		bit no_gap;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [COORD_W-1:0] x_coord = '0;
	logic signed [COORD_W-1:0] y_coord = '0;
	logic signed [COORD_W-1:0] z_coord = '0;
	logic last_point = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [OUT_IDX_W-1:0] min_index;
	logic [OUT_IDX_W-1:0] max_index;
	logic signed [DIST_W-1:0] min_distance;
	logic signed [DIST_W-1:0] max_distance;
	logic index_overflow;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0] cfg_data = '0;

	point_t point_queue[$];
	result_t expected_extremes[$];
	int mismatches = 0;

	logic signed [COORD_W-1:0] plane_nx = '0;
	logic signed [COORD_W-1:0] plane_ny = '0;
	logic signed [COORD_W-1:0] plane_nz = NORMAL_Z_RESET;
	logic signed [COORD_W-1:0] plane_off = '0;

	int unsigned cloud_count = 0;
	bit cloud_started = 1'b0;
	logic signed [DIST_W-1:0] low_dist = '0;
	logic signed [DIST_W-1:0] high_dist = '0;
	logic [31:0] low_idx = '0;
	logic [31:0] high_idx = '0;
	bit cloud_overflow = 1'b0;

	int send_gap = 0;
	int send_calm = 0;
	bit send_next;
	int recv_gap = 0;
	int recv_calm = 0;

	plane_distance_extremes #(
		.MAX_POINTS(MAX_PTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.z_coord(z_coord),
		.last_point(last_point),
		.empty(empty),
		.pop(pop),
		.min_index(min_index),
		.max_index(max_index),
		.min_distance(min_distance),
		.max_distance(max_distance),
		.index_overflow(index_overflow),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic signed [DIST_W-1:0] plane_distance_q16(
		logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
		logic signed [COORD_W-1:0] z);
		logic signed [67:0] a, b, c, px, py, pz, acc;
		a = plane_nx;
		b = plane_ny;
		c = plane_nz;
		px = x;
		py = y;
		pz = z;
		acc = a * px + b * py + c * pz + (68'sd1 <<< (FRAC_SHIFT - 1));
		acc = acc >>> FRAC_SHIFT;
		acc = acc + plane_off;
		return acc[DIST_W-1:0];
	endfunction

	function automatic void fold_point(point_t p);
		logic signed [DIST_W-1:0] d;
		logic [31:0] idx;
		result_t r;
		d = plane_distance_q16(p.x, p.y, p.z);
		if (cloud_count >= MAX_PTS) begin
			cloud_overflow = 1'b1;
			idx = MAX_PTS - 1;
		end else begin
			idx = cloud_count;
			cloud_count++;
		end
		if (!cloud_started) begin
			cloud_started = 1'b1;
			low_dist = d;
			high_dist = d;
			low_idx = idx;
			high_idx = idx;
		end else begin
			if (d < low_dist) begin
				low_dist = d;
				low_idx = idx;
			end
			if (d > high_dist) begin
				high_dist = d;
				high_idx = idx;
			end
		end
		if (p.last) begin
			r.min_index = low_idx[OUT_IDX_W-1:0];
			r.max_index = high_idx[OUT_IDX_W-1:0];
			r.min_distance = low_dist;
			r.max_distance = high_dist;
			r.overflow = cloud_overflow;
			expected_extremes.insert(expected_extremes.size(), r);
			cloud_count = 0;
			cloud_started = 1'b0;
			low_dist = '0;
			high_dist = '0;
			low_idx = '0;
			high_idx = '0;
			cloud_overflow = 1'b0;
		end
	endfunction

	// mostly short gaps, a few long ones, and occasional stretches with none
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 199);
		if (r == 0) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 40);
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			v = int'($urandom_range(0, 8)) - 4;
			return v * 65536;
		end else if (r < 45) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7fff_ffff;
				1: return 32'sh8000_0000;
				2: return 32'sh0000_0000;
				default: return 32'shffff_ffff;
			endcase
		end else if (r < 70) begin
			return int'($urandom_range(0, 2000000)) - 1000000;
		end else begin
			return $urandom;
		end
	endfunction

	function automatic logic [COORD_W-1:0] rand_plane_word();
		int r;
		logic [COORD_W-1:0] v;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			case ($urandom_range(0, 4))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0000_0000;
				3: return 32'h4000_0000;
				default: return 32'hc000_0000;
			endcase
		end else if (r < 60) begin
			v = $urandom_range(0, 32'h4000_0000);
			return $urandom_range(0, 1) ? -v : v;
		end else begin
			return $urandom;
		end
	endfunction

	function automatic int pick_cloud_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return $urandom_range(1, 6);
		else if (r < 90)
			return $urandom_range(7, 30);
		else
			return $urandom_range(31, 120);
	endfunction

	task automatic add_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
		logic signed [COORD_W-1:0] z, logic last, bit no_gap);
		point_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		p.last = last;
		p.no_gap = no_gap;
		point_queue.insert(point_queue.size(), p);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_NORMAL_X: plane_nx = val;
			CFG_NORMAL_Y: plane_ny = val;
			CFG_NORMAL_Z: plane_nz = val;
			CFG_PLANE_OFFSET: plane_off = val;
			default: ;
		endcase
	endtask

	task automatic set_plane(logic [COORD_W-1:0] nx, logic [COORD_W-1:0] ny,
		logic [COORD_W-1:0] nz, logic [COORD_W-1:0] off, bit stray);
		if (stray)
			write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNMAPPED, CFG_LAST_INDEX)),
				$urandom);
		write_reg(CFG_NORMAL_X, nx);
		write_reg(CFG_NORMAL_Y, ny);
		write_reg(CFG_NORMAL_Z, nz);
		write_reg(CFG_PLANE_OFFSET, off);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (point_queue.size() != 0 || expected_extremes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_extremes();
		result_t e;
		if (expected_extremes.size() == 0) begin
			$display("%0t unexpected transaction min_index %0d max_index %0d", $time,
				min_index, max_index);
			mismatches++;
		end else begin
			e = expected_extremes.pop_front();
			if (min_index !== e.min_index) begin
				$display("%0t min_index exp %0d got %0d", $time, e.min_index, min_index);
				mismatches++;
			end
			if (max_index !== e.max_index) begin
				$display("%0t max_index exp %0d got %0d", $time, e.max_index, max_index);
				mismatches++;
			end
			if (min_distance !== e.min_distance) begin
				$display("%0t min_distance exp %0d got %0d", $time, e.min_distance,
					min_distance);
				mismatches++;
			end
			if (max_distance !== e.max_distance) begin
				$display("%0t max_distance exp %0d got %0d", $time, e.max_distance,
					max_distance);
				mismatches++;
			end
			if (index_overflow !== e.overflow) begin
				$display("%0t index_overflow exp %0b got %0b", $time, e.overflow,
					index_overflow);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				fold_point(point_queue[0]);
				void'(point_queue.pop_front());
				if (point_queue.size() != 0 && point_queue[0].no_gap)
					send_gap = 0;
				else
					send_gap = pick_gap(send_calm);
			end
			if (push && full) begin
				send_next = 1'b1;
			end else if (send_gap > 0) begin
				send_gap--;
				send_next = 1'b0;
			end else if (point_queue.size() != 0) begin
				send_next = 1'b1;
				x_coord <= point_queue[0].x;
				y_coord <= point_queue[0].y;
				z_coord <= point_queue[0].z;
				last_point <= point_queue[0].last;
			end else begin
				send_next = 1'b0;
			end
			push <= send_next;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				check_extremes();
				recv_gap = pick_gap(recv_calm);
			end
			if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		int i;
		int csize;
		int phase_items;
		int rand_count;
		rand_count = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// plane after reset: distance is z plus zero offset
		add_point(32'sd0, 32'sd0, 32'sd5 <<< 16, 1'b1, 1'b0);
		add_point(32'sd0, 32'sd0, 32'sh7fff_ffff, 1'b0, 1'b0);
		add_point(32'sd0, 32'sd0, 32'sh8000_0000, 1'b0, 1'b0);
		add_point(32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0);
		add_point(32'sd0, 32'sd0, 32'sh7fff_ffff, 1'b0, 1'b0);
		add_point(32'sd0, 32'sd0, 32'sh8000_0000, 1'b1, 1'b0);

		wait_idle();
		set_plane(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
		write_reg(CFG_IDX_W'(CFG_LAST_INDEX), 32'hffff_ffff);
		cfg_valid <= 1'b0;
		@(negedge clk);
		add_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0, 1'b0);
		add_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b0);
		add_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0, 1'b0);
		add_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1, 1'b0);

		wait_idle();
		set_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
		add_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0, 1'b0);
		add_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1, 1'b0);

		// half-way rounding on both signs
		wait_idle();
		set_plane(32'h2000_0000, 32'he000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
		add_point(32'sd1, 32'sd0, 32'sd0, 1'b0, 1'b0);
		add_point(32'sd0, 32'sd1, 32'sd0, 1'b0, 1'b0);
		add_point(32'sd0, 32'sd3, 32'sd0, 1'b0, 1'b0);
		add_point(32'sd1, 32'sd1, 32'sd0, 1'b1, 1'b0);

		// long back-to-back cloud, late points set both extremes
		wait_idle();
		set_plane(32'h0000_0000, 32'h0000_0000, NORMAL_Z_RESET, 32'h0000_0000, 1'b0);
		for (i = 0; i < PHASE_ITEMS; i++)
			add_point(rand_coord(), rand_coord(), int'($urandom_range(0, 8)) - 4, 1'b0, 1'b1);
		add_point(32'sd0, 32'sd0, 32'sh8000_0000, 1'b0, 1'b1);
		add_point(32'sd0, 32'sd0, 32'sh7fff_ffff, 1'b1, 1'b1);

		while (rand_count < RANDOM_ITEMS) begin
			wait_idle();
			set_plane(rand_plane_word(), rand_plane_word(), rand_plane_word(),
				rand_plane_word(), $urandom_range(0, 3) == 0);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				csize = pick_cloud_size();
				for (i = 0; i < csize; i++)
					add_point(rand_coord(), rand_coord(), rand_coord(), i == csize - 1, 1'b0);
				phase_items += csize;
			end
			rand_count += phase_items;
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
